// ===== src/djsvf_pkg.sv =====
// Shared types and constants of the DJ state-variable filter.
// Used by the configuration port, the multiply-accumulate unit and the top level.
// No dependencies.
package djsvf_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W  = 12;   // input sample
    localparam int OUT_W     = 22;   // output sample
    localparam int KNOB_W    = 12;   // knob register
    localparam int STATE_W   = 22;   // integrator states
    localparam int WIDE_W    = 24;   // unclamped intermediate values
    localparam int G_W       = 15;   // cutoff coefficient, at most 22000
    localparam int R_W       = 17;   // knob ratio and taper terms
    localparam int DIV_W     = 11;   // knob offset inside one side
    localparam int Q_SHIFT   = 15;   // Q15 fixed point
    localparam int NUM_W     = DIV_W + Q_SHIFT;
    localparam int OP_A_W    = 28;
    localparam int OP_B_W    = 18;
    localparam int ACC_W     = 48;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // Knob register.
    localparam logic [KNOB_W-1:0] KNOB_RESET = KNOB_W'(2048);
    localparam logic [KNOB_W-1:0] BYPASS_LO  = KNOB_W'(1800);
    localparam logic [KNOB_W-1:0] BYPASS_HI  = KNOB_W'(2300);
    localparam int                KNOB_MAX   = 4095;
    localparam logic              REG_KNOB   = 1'b0;  // register index, from paddr[2]

    // Ratio of the knob inside its side: divisors and reciprocals.
    localparam int DIV_SHIFT  = NUM_W;
    localparam int DIV_LO     = 1800;
    localparam int DIV_HI     = KNOB_MAX - 2300;
    localparam int RECIP_LO   = (1 << DIV_SHIFT) / DIV_LO;
    localparam int RECIP_HI   = (1 << DIV_SHIFT) / DIV_HI;

    // Cubic taper and coefficient limits.
    localparam int TAPER_C1   = 4000;
    localparam int TAPER_C2   = 10000;
    localparam int TAPER_C3   = 18768;
    localparam int G_OFFSET   = 300;
    localparam int G_MIN      = 150;
    localparam int G_MAX      = 22000;

    // Filter constants.
    localparam int RESONANCE   = 12000;
    localparam int STATE_MAX   = 1 << 20;
    localparam int OUT_MAX     = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN     = -(1 << (OUT_W - 1));
    localparam int BLEED_SHIFT = 6;

    // One operation for the shared multiply-accumulate unit.
    typedef struct packed {
        logic                     acc_en;
        logic signed [OP_A_W-1:0] a;
        logic signed [OP_B_W-1:0] b;
    } mac_op_t;

    // Knob value and its write strobe.
    typedef struct packed {
        logic              wr;
        logic [KNOB_W-1:0] knob;
    } cfg_t;

endpackage

// ===== src/dj_state_variable_filter.sv =====
// Knob-controlled DJ filter: one Chamberlin state-variable step per audio word.
// A word is accepted only while the sequencer is idle, so the next word waits until the
// previous result is in the output register. The shared multiplier is used three times
// per filtered word under the sequencer; bypass words do not use it.
// A knob write starts a coefficient update during which s_axis_tready is low.
// Synchronous active-low reset: knob 2048 (bypass), integrators zero, no word pending.
module dj_state_variable_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream. tdata: [11:0] sample_in, upper bits unused.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [djsvf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // Output stream. tdata: [21:0] sample_out, upper bits zero.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [djsvf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [djsvf_pkg::ADDR_W-1:0]       paddr,
    input  logic [djsvf_pkg::DATA_W-1:0]       pwdata,
    output logic [djsvf_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);
    import djsvf_pkg::*;

    // Sequencer states. The G_ states compute the cutoff coefficient after a knob
    // write; the F_ states run one filter step.
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_G_DIV   = 5'd1;
    localparam logic [4:0] ST_G_EST   = 5'd2;
    localparam logic [4:0] ST_G_CORR  = 5'd3;
    localparam logic [4:0] ST_G_SQ    = 5'd4;
    localparam logic [4:0] ST_G_CUBE  = 5'd5;
    localparam logic [4:0] ST_G_MIX1  = 5'd6;
    localparam logic [4:0] ST_G_MIX2  = 5'd7;
    localparam logic [4:0] ST_G_MIX3  = 5'd8;
    localparam logic [4:0] ST_G_TAPER = 5'd9;
    localparam logic [4:0] ST_F_RES   = 5'd10;
    localparam logic [4:0] ST_F_HP    = 5'd11;
    localparam logic [4:0] ST_F_GHP   = 5'd12;
    localparam logic [4:0] ST_F_BNEW  = 5'd13;
    localparam logic [4:0] ST_F_GB    = 5'd14;
    localparam logic [4:0] ST_F_LP    = 5'd15;
    localparam logic [4:0] ST_DONE    = 5'd16;

    localparam logic signed [STATE_W-1:0] S_HI = STATE_W'(STATE_MAX);
    localparam logic signed [STATE_W-1:0] S_LO = STATE_W'(-STATE_MAX);
    localparam logic signed [WIDE_W-1:0]  W_S_HI = WIDE_W'(STATE_MAX);
    localparam logic signed [WIDE_W-1:0]  W_S_LO = WIDE_W'(-STATE_MAX);
    localparam logic signed [WIDE_W-1:0]  W_O_HI = WIDE_W'(OUT_MAX);
    localparam logic signed [WIDE_W-1:0]  W_O_LO = WIDE_W'(OUT_MIN);
    localparam logic signed [ACC_W-1:0]   A_G_HI = ACC_W'(G_MAX);
    localparam logic signed [ACC_W-1:0]   A_G_LO = ACC_W'(G_MIN);

    // Clamp a wide value into the integrator range.
    function automatic logic signed [STATE_W-1:0] clamp_state(
        input logic signed [WIDE_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > W_S_HI) begin
            r = S_HI;
        end else if (v < W_S_LO) begin
            r = S_LO;
        end else begin
            r = STATE_W'(v);
        end
        return r;
    endfunction

    // Saturate a wide value into the output field.
    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [WIDE_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > W_O_HI) begin
            r = OUT_W'(OUT_MAX);
        end else if (v < W_O_LO) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    cfg_t                      cfg;
    mac_op_t                   op;
    logic signed [ACC_W-1:0]   acc;

    djsvf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    djsvf_mac u_mac (
        .aclk (aclk),
        .op   (op),
        .acc  (acc)
    );

    // Control and state registers.
    logic [4:0]                 state_reg, state_next;
    logic signed [STATE_W-1:0]  b_reg, b_next;
    logic signed [STATE_W-1:0]  l_reg, l_next;
    logic                       m_valid_reg, m_valid_next;

    // Payload registers.
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                       low_reg, low_next;
    logic signed [WIDE_W-1:0]   hp_reg, hp_next;
    logic signed [WIDE_W-1:0]   bn_reg, bn_next;
    logic [R_W-1:0]             q_reg, q_next;
    logic [R_W-1:0]             r_reg, r_next;
    logic [R_W-1:0]             quad_reg, quad_next;
    logic [G_W-1:0]             g_reg, g_next;
    logic signed [OUT_W-1:0]    res_reg, res_next;
    logic signed [OUT_W-1:0]    m_data_reg, m_data_next;

    // Knob decode. The low side divides the knob by 1800, the high side divides
    // the offset above 2300 by 1795; both use a reciprocal product and one correction.
    logic                        knob_low;
    logic                        knob_high;
    logic [KNOB_W-1:0]           knob_diff;
    logic [NUM_W-1:0]            num_cur;
    logic [DIV_W-1:0]            div_cur;
    logic [OP_B_W-1:0]           recip_cur;
    logic signed [NUM_W+2:0]     rem;
    logic signed [NUM_W+2:0]     div_ext;
    logic [R_W-1:0]              q_est;

    // Datapath views of the accumulator.
    logic signed [ACC_W-1:0]     acc_shr;
    logic signed [WIDE_W-1:0]    acc_w;
    logic signed [ACC_W-1:0]     mix_sum;
    logic signed [WIDE_W-1:0]    lp;
    logic signed [SAMPLE_W-1:0]  sample_in;

    assign knob_low  = (cfg.knob < BYPASS_LO);
    assign knob_high = (cfg.knob > BYPASS_HI);
    assign knob_diff = cfg.knob - BYPASS_HI;
    assign num_cur   = knob_low ? {cfg.knob[DIV_W-1:0], {Q_SHIFT{1'b0}}}
                                : {knob_diff[DIV_W-1:0], {Q_SHIFT{1'b0}}};
    assign div_cur   = knob_low ? DIV_W'(DIV_LO) : DIV_W'(DIV_HI);
    assign recip_cur = knob_low ? OP_B_W'(RECIP_LO) : OP_B_W'(RECIP_HI);
    assign q_est     = acc[DIV_SHIFT+R_W-1:DIV_SHIFT];
    assign div_ext   = (NUM_W+3)'(div_cur);
    assign rem       = (NUM_W+3)'(num_cur) - (NUM_W+3)'(acc[NUM_W:0]);

    assign acc_shr   = acc >>> Q_SHIFT;
    assign acc_w     = acc_shr[WIDE_W-1:0];
    assign mix_sum   = acc_shr + ACC_W'(G_OFFSET);
    assign lp        = WIDE_W'(l_reg) + acc_w;
    assign sample_in = s_axis_tdata[SAMPLE_W-1:0];

    // A knob write takes precedence, so no word is accepted at the same edge.
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg.wr;

    always_comb begin
        state_next   = state_reg;
        b_next       = b_reg;
        l_next       = l_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        low_next     = low_reg;
        hp_next      = hp_reg;
        bn_next      = bn_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        quad_next    = quad_reg;
        g_next       = g_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        op           = '0;

        // The output word leaves when the consumer takes it.
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    x_next   = sample_in;
                    low_next = knob_low;
                    if (knob_low || knob_high) begin
                        state_next = ST_F_RES;
                    end else begin
                        // Bypass: pass the sample and let both integrators bleed.
                        b_next     = b_reg - (b_reg >>> BLEED_SHIFT);
                        l_next     = l_reg - (l_reg >>> BLEED_SHIFT);
                        res_next   = OUT_W'(sample_in);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_G_DIV: begin
                op.a       = OP_A_W'(num_cur);
                op.b       = recip_cur;
                state_next = ST_G_EST;
            end
            ST_G_EST: begin
                // The estimate is the true quotient or one below it.
                q_next     = q_est;
                op.a       = OP_A_W'(q_est);
                op.b       = OP_B_W'(div_cur);
                state_next = ST_G_CORR;
            end
            ST_G_CORR: begin
                r_next     = (rem >= div_ext) ? R_W'(q_reg + 1'b1) : q_reg;
                state_next = ST_G_SQ;
            end
            ST_G_SQ: begin
                op.a       = OP_A_W'(r_reg);
                op.b       = OP_B_W'(r_reg);
                state_next = ST_G_CUBE;
            end
            ST_G_CUBE: begin
                quad_next  = acc_shr[R_W-1:0];
                op.a       = OP_A_W'(acc_shr[R_W-1:0]);
                op.b       = OP_B_W'(r_reg);
                state_next = ST_G_MIX1;
            end
            ST_G_MIX1: begin
                op.a       = OP_A_W'(acc_shr[R_W-1:0]);
                op.b       = OP_B_W'(TAPER_C3);
                state_next = ST_G_MIX2;
            end
            ST_G_MIX2: begin
                op.acc_en  = 1'b1;
                op.a       = OP_A_W'(quad_reg);
                op.b       = OP_B_W'(TAPER_C2);
                state_next = ST_G_MIX3;
            end
            ST_G_MIX3: begin
                op.acc_en  = 1'b1;
                op.a       = OP_A_W'(r_reg);
                op.b       = OP_B_W'(TAPER_C1);
                state_next = ST_G_TAPER;
            end
            ST_G_TAPER: begin
                if (mix_sum > A_G_HI) begin
                    g_next = G_W'(G_MAX);
                end else if (mix_sum < A_G_LO) begin
                    g_next = G_W'(G_MIN);
                end else begin
                    g_next = mix_sum[G_W-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_F_RES: begin
                op.a       = OP_A_W'(b_reg);
                op.b       = OP_B_W'(RESONANCE);
                state_next = ST_F_HP;
            end
            ST_F_HP: begin
                hp_next    = WIDE_W'(x_reg) - acc_w - WIDE_W'(l_reg);
                state_next = ST_F_GHP;
            end
            ST_F_GHP: begin
                op.a       = OP_A_W'(hp_reg);
                op.b       = OP_B_W'(g_reg);
                state_next = ST_F_BNEW;
            end
            ST_F_BNEW: begin
                bn_next    = WIDE_W'(b_reg) + acc_w;
                state_next = ST_F_GB;
            end
            ST_F_GB: begin
                // The low-pass update uses the band value before clamping.
                op.a       = OP_A_W'(bn_reg);
                op.b       = OP_B_W'(g_reg);
                state_next = ST_F_LP;
            end
            ST_F_LP: begin
                b_next     = clamp_state(bn_reg);
                l_next     = clamp_state(lp);
                res_next   = sat_out(low_reg ? lp : hp_reg);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.wr) begin
            state_next = ST_G_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            b_reg       <= '0;
            l_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            b_reg       <= b_next;
            l_reg       <= l_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        low_reg    <= low_next;
        hp_reg     <= hp_next;
        bn_reg     <= bn_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        quad_reg   <= quad_next;
        g_reg      <= g_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, m_data_reg};

    // Both integrators always stay inside their clamp range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_reg <= S_HI) && (b_reg >= S_LO) && (l_reg <= S_HI) && (l_reg >= S_LO))
        else $error("integrator state out of range");

    // The reciprocal estimate never misses the quotient by more than one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_G_CORR) |-> (rem >= 0) && (rem < (div_ext <<< 1)))
        else $error("knob ratio estimate off by more than one");

    // A finished coefficient update leaves the cutoff inside its limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_G_TAPER) |=> (g_reg >= G_W'(G_MIN)) && (g_reg <= G_W'(G_MAX)))
        else $error("cutoff coefficient out of range");

    // An accepted word takes the sequencer out of idle in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    // A result waiting with a free output register is presented next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && !m_valid_reg && !cfg.wr |=> m_valid_reg)
        else $error("result not loaded into output register");

endmodule

// ===== src/djsvf_mac.sv =====
// Shared multiply-accumulate unit of the DJ state-variable filter.
// Depends on djsvf_pkg.
module djsvf_mac (
    input  logic                                  aclk,
    input  djsvf_pkg::mac_op_t                    op,
    output logic signed [djsvf_pkg::ACC_W-1:0]    acc
);
    import djsvf_pkg::*;

    logic signed [OP_A_W+OP_B_W-1:0] prod;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         acc_next;

    // One signed product per cycle, optionally added to the previous sum.
    assign prod     = op.a * op.b;
    assign acc_next = (op.acc_en ? acc_reg : '0) + ACC_W'(prod);

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== src/djsvf_cfg.sv =====
// APB-style configuration port holding the knob register.
// Depends on djsvf_pkg.
module djsvf_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [djsvf_pkg::ADDR_W-1:0]   paddr,
    input  logic [djsvf_pkg::DATA_W-1:0]   pwdata,
    output logic [djsvf_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output djsvf_pkg::cfg_t                cfg
);
    import djsvf_pkg::*;

    logic [KNOB_W-1:0] knob_reg;
    logic [KNOB_W-1:0] knob_next;
    logic              hit;
    logic              wr;

    assign pready = 1'b1;
    assign hit    = (paddr[ADDR_W-1] == REG_KNOB);
    assign wr     = psel && penable && pwrite && hit;

    assign knob_next = wr ? pwdata[KNOB_W-1:0] : knob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knob_reg <= KNOB_RESET;
        end else begin
            knob_reg <= knob_next;
        end
    end

    assign prdata = hit ? DATA_W'(knob_reg) : '0;
    assign cfg    = '{wr: wr, knob: knob_reg};

endmodule

// ===== tb/dj_state_variable_filter_tb.sv =====
// Self-checking testbench for the knob-controlled DJ state-variable filter.
// Drives audio words and knob writes, predicts every output word with its own filter model.
// Depends on djsvf_pkg and dj_state_variable_filter.
module dj_state_variable_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import djsvf_pkg::*;

    // Register map: the knob is register 0; address 4 decodes to no register at all.
    localparam logic [ADDR_W-1:0] ADDR_KNOB     = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam int RANDOM_WORDS   = 1650;
    localparam int SETTLE_CYCLES  = 12;    // a little more than the filtering latency
    localparam int HOLD_CYCLES    = 300;   // long output back-pressure stretch
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake

    typedef enum logic {
        ROW_WRITE,  // knob register write at addr with value
        ROW_WORD    // one audio word
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [ADDR_W-1:0]        addr;
        logic [DATA_W-1:0]        value;
        logic [SAMPLE_W-1:0]      sample;
        logic                     has_lit;   // output typed in below rather than predicted
        logic signed [OUT_W-1:0]  lit;
    } row_t;

    typedef enum {
        PAT_NOISE,   // uniform random samples
        PAT_SQUARE,  // full-scale square wave, drives the integrators hard
        PAT_QUIET    // a few LSBs around zero
    } pattern_t;

    localparam int NUM_ROWS = 27;

    // Directed part. Bypass rows carry their output directly, since bypass passes
    // the sample through untouched; filtering rows go through the predictor.
    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // Reset leaves the knob at 2048, which is bypass.
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b1,  22'sd2047},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b1, -22'sd2048},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h000, 1'b1,  22'sd0},
        // Low-pass at the bottom of the knob: smallest cutoff.
        '{ROW_WRITE, ADDR_KNOB, 32'd0,         12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h555, 1'b0,  22'sd0},
        // Low-pass just below the bypass band: cutoff clamped at its top.
        '{ROW_WRITE, ADDR_KNOB, 32'd1799,      12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b0,  22'sd0},
        // Both edges of the bypass band; the integrators bleed meanwhile.
        '{ROW_WRITE, ADDR_KNOB, 32'd1800,      12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h123, 1'b1,  22'sd291},
        '{ROW_WRITE, ADDR_KNOB, 32'd2300,      12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'hFFF, 1'b1, -22'sd1},
        // High-pass from just above the band up to the end of the knob.
        '{ROW_WRITE, ADDR_KNOB, 32'd2301,      12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'hAAA, 1'b0,  22'sd0},
        '{ROW_WRITE, ADDR_KNOB, 32'd4095,      12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0},
        // A write to an unmapped address must leave the knob at 4095.
        '{ROW_WRITE, ADDR_UNMAPPED, 32'd0,     12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h001, 1'b0,  22'sd0},
        // Bits above the knob width are dropped: this lands on 0x100, low-pass.
        '{ROW_WRITE, ADDR_KNOB, 32'hFFFFF100,  12'h000, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h800, 1'b0,  22'sd0},
        '{ROW_WORD,  ADDR_KNOB, 32'd0,         12'h7FF, 1'b0,  22'sd0}
    };

    // Clock, reset and the block's ports; every driven input is at a known value from time zero.
    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [11:0] sample_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // [21:0] sample_out
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [ADDR_W-1:0]      paddr         = '0;
    logic [DATA_W-1:0]      pwdata        = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    // Shadow of the block: knob register and the two integrators.
    logic [KNOB_W-1:0]       knob_q  = KNOB_RESET;
    longint                  band_q  = 0;
    longint                  low_q   = 0;

    logic signed [OUT_W-1:0] filtered_q [$];   // output words still owed by the block
    logic signed [OUT_W-1:0] owed_word;
    int                      failures      = 0;
    int                      quiet_cycles  = 0;
    int                      hold_left     = 0;
    bit                      hold_request  = 1'b0;
    bit                      hold_done     = 1'b0;
    bit                      steady        = 1'b0;   // both sides stop idling

    dj_state_variable_filter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Cubic taper of the knob ratio r (Q15) into the cutoff coefficient.
    function automatic longint cutoff_gain(input longint r);
        longint quad, cubic, mixed;
        quad  = (r * r) >>> Q_SHIFT;
        cubic = (quad * r) >>> Q_SHIFT;
        mixed = (r * TAPER_C1 + quad * TAPER_C2 + cubic * TAPER_C3) >>> Q_SHIFT;
        return clip(G_OFFSET + mixed, G_MIN, G_MAX);
    endfunction

    // One filter step on the shadow state; returns the output word it yields.
    // All products are 64-bit so nothing wraps, and >>> floors like the block.
    function automatic logic signed [OUT_W-1:0] filter_word(input logic signed [SAMPLE_W-1:0] x);
        longint k, xs, b, l, g, hp, lp;
        bit     low_mode;
        k  = longint'(knob_q);
        xs = longint'(x);
        b  = band_q;
        l  = low_q;
        if (k < longint'(BYPASS_LO)) begin
            low_mode = 1'b1;
            g = cutoff_gain((k << Q_SHIFT) / DIV_LO);
        end else if (k > longint'(BYPASS_HI)) begin
            low_mode = 1'b0;
            g = cutoff_gain(((k - longint'(BYPASS_HI)) << Q_SHIFT) / DIV_HI);
        end else begin
            // Bypass: the sample goes straight out and both integrators decay by 1/64.
            band_q = b - (b >>> BLEED_SHIFT);
            low_q  = l - (l >>> BLEED_SHIFT);
            return OUT_W'(xs);
        end
        hp = xs - ((longint'(RESONANCE) * b) >>> Q_SHIFT) - l;
        b  = b + ((g * hp) >>> Q_SHIFT);
        // The low-pass update sees the band value before it is clamped.
        lp = l + ((g * b) >>> Q_SHIFT);
        band_q = clip(b, -STATE_MAX, STATE_MAX);
        low_q  = clip(lp, -STATE_MAX, STATE_MAX);
        // Only the low-pass output can run past the 22-bit range; it saturates.
        return OUT_W'(clip(low_mode ? lp : hp, OUT_MIN, OUT_MAX));
    endfunction

    // Offers one audio word and waits for the handshake. Valid stays high after
    // acceptance so back-to-back words never see valid dropped within one step.
    task automatic push_word(input logic [SAMPLE_W-1:0] sample,
                             input bit has_lit, input logic signed [OUT_W-1:0] lit);
        logic signed [OUT_W-1:0] predicted;
        while (!steady && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(sample);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = filter_word(sample);
        filtered_q.push_back(has_lit ? lit : predicted);
    endtask

    // Brings the block to rest: no word offered, every owed word delivered, and
    // a settling wait of SETTLE_CYCLES so the datapath is at rest before the knob moves.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Two-phase register write; the register takes the value in the access cycle.
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KNOB) begin
            knob_q = data[KNOB_W-1:0];
        end
    endtask

    // Stimulus: reset, the directed table, then random phases at random knob settings.
    initial begin
        int                  sent;
        int                  phase;
        int                  len;
        int                  period;
        pattern_t            pattern;
        logic [KNOB_W-1:0]   knob;
        logic [SAMPLE_W-1:0] sample;

        sent  = 0;
        phase = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIRECTED_ROWS[i].kind == ROW_WRITE) begin
                reg_write(DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].value);
            end else begin
                push_word(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].has_lit,
                          DIRECTED_ROWS[i].lit);
            end
        end

        while (sent < RANDOM_WORDS) begin
            // Knob choice leans on the mode edges and the two ends of the travel.
            case ($urandom_range(0, 11))
                0:       knob = 12'd0;
                1:       knob = 12'd1799;
                2:       knob = 12'd1800;
                3:       knob = 12'd2300;
                4:       knob = 12'd2301;
                5:       knob = 12'd4095;
                6:       knob = KNOB_W'($urandom_range(1700, 1799));
                7:       knob = KNOB_W'($urandom_range(1800, 2300));
                8, 9:    knob = KNOB_W'($urandom_range(0, 1799));
                default: knob = KNOB_W'($urandom_range(2301, 4095));
            endcase
            if ($urandom_range(0, 5) == 0) begin
                reg_write(ADDR_UNMAPPED, $urandom());
            end
            // Upper bits of the write data are junk that the block must drop.
            reg_write(ADDR_KNOB, {20'($urandom()), knob});

            case ($urandom_range(0, 4))
                0, 1:    pattern = PAT_NOISE;
                2, 3:    pattern = PAT_SQUARE;
                default: pattern = PAT_QUIET;
            endcase
            period = $urandom_range(1, 16);
            len    = $urandom_range(10, 80);
            steady = (phase == 2);
            if (phase == 4) begin
                // The sink holds off for a long stretch while words keep coming,
                // so the block fills up and must stall its input.
                hold_request = 1'b1;
            end

            for (int n = 0; n < len; n++) begin
                case (pattern)
                    PAT_SQUARE: sample = ((n / period) % 2) ? 12'h800 : 12'h7FF;
                    PAT_QUIET:  sample = SAMPLE_W'($urandom_range(0, 15) - 8);
                    default:    sample = SAMPLE_W'($urandom());
                endcase
                push_word(sample, 1'b0, '0);
            end
            sent  += len;
            steady = 1'b0;
            phase++;
        end

        drain_block();
        if (failures == 0) begin
            $display("dj_state_variable_filter: match");
        end else begin
            $display("dj_state_variable_filter: mismatch");
        end
        $finish;
    end

    // Output side: checks each delivered word against the oldest owed word, then
    // picks the next ready value (random stalls, or the one long hold-off).
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (filtered_q.size() == 0) begin
                $error("sample_out: expected no word, actual %0d",
                       $signed(m_axis_tdata[OUT_W-1:0]));
                failures++;
            end else begin
                owed_word = filtered_q.pop_front();
                if (m_axis_tdata[OUT_W-1:0] !== owed_word) begin
                    $error("sample_out: expected %0d, actual %0d",
                           owed_word, $signed(m_axis_tdata[OUT_W-1:0]));
                    failures++;
                end
                if (m_axis_tdata[M_TDATA_W-1:OUT_W] !== '0) begin
                    $error("tdata padding: expected 0, actual %0h",
                           m_axis_tdata[M_TDATA_W-1:OUT_W]);
                    failures++;
                end
            end
        end

        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    // Watchdog: any handshake on either stream or the register port counts as progress.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dj_state_variable_filter: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
